@@ rtl/r2fft_pkg.sv @@
// Shared constants, operation codes and twiddle table builder for the radix-2 FFT core.
package r2fft_pkg;

	localparam int TW_W = 16;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam int LOG2_REG_W = 4;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOG2_POINTS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 1'd1;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Taylor term divisors (2n-1)(2n) for cosine
	function automatic longint unsigned cos_div(input longint unsigned v, input int n);
		longint unsigned r;
		r = v;
		case (n)
			1: r = v / 2;
			2: r = v / 12;
			3: r = v / 30;
			4: r = v / 56;
			5: r = v / 90;
			6: r = v / 132;
			7: r = v / 182;
			8: r = v / 240;
			9: r = v / 306;
			10: r = v / 380;
			11: r = v / 462;
			default: r = v / 552;
		endcase
		return r;
	endfunction

	// Taylor term divisors (2n)(2n+1) for sine
	function automatic longint unsigned sin_div(input longint unsigned v, input int n);
		longint unsigned r;
		r = v;
		case (n)
			1: r = v / 6;
			2: r = v / 20;
			3: r = v / 42;
			4: r = v / 72;
			5: r = v / 110;
			6: r = v / 156;
			7: r = v / 210;
			8: r = v / 272;
			9: r = v / 342;
			10: r = v / 420;
			11: r = v / 506;
			default: r = v / 600;
		endcase
		return r;
	endfunction

	function automatic logic [TW_W-1:0] to_q15(input longint sv);
		longint q;
		longint t;
		t = (sv < 0) ? 64'sd0 : sv;
		q = (t + 64'sd16384) >>> 15;
		if (q > 64'sd32767)
			q = 64'sd32767;
		return q[TW_W-1:0];
	endfunction

	// {sin, cos} of 2*pi*r/2^lg, first quadrant
	function automatic logic [2*TW_W-1:0] quarter_trig(input longint unsigned r, input int lg);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tc;
		longint unsigned ts;
		longint sc;
		longint ss;
		x = (64'd2 * r * PI_Q30 + ((64'd1 << lg) >> 1)) >> lg;
		x2 = (x * x) >> 30;
		tc = 64'd1 << 30;
		ts = x;
		sc = longint'(tc);
		ss = longint'(ts);
		for (int n = 1; n <= 12; n++) begin
			tc = cos_div((tc * x2) >> 30, n);
			ts = sin_div((ts * x2) >> 30, n);
			if (n % 2 == 1) begin
				sc = sc - longint'(tc);
				ss = ss - longint'(ts);
			end else begin
				sc = sc + longint'(tc);
				ss = ss + longint'(ts);
			end
		end
		return {to_q15(ss), to_q15(sc)};
	endfunction

	// Table entry m of a 2^lg point transform: {sin, cos}
	function automatic logic [2*TW_W-1:0] tw_entry(input int m, input int lg);
		longint unsigned quarter;
		logic [2*TW_W-1:0] cs;
		logic [TW_W-1:0] nsin;
		quarter = (64'd1 << lg) >> 2;
		if (longint'(m) <= longint'(quarter)) begin
			cs = quarter_trig(longint'(m), lg);
		end else begin
			cs = quarter_trig(longint'(m) - quarter, lg);
			nsin = -cs[2*TW_W-1:TW_W];
			cs = {cs[TW_W-1:0], nsin};
		end
		return cs;
	endfunction

endpackage

@@ rtl/r2fft_bfly.sv @@
// Pipelined butterfly datapath: twiddle multiply, Q15 rounding, saturating add and subtract.
module r2fft_bfly #(
	parameter int BIN_W = 27
) (
	input  logic                                  clk,
	input  logic signed [BIN_W-1:0]               a_re,
	input  logic signed [BIN_W-1:0]               a_im,
	input  logic signed [BIN_W-1:0]               b_re,
	input  logic signed [BIN_W-1:0]               b_im,
	input  logic signed [r2fft_pkg::TW_W-1:0]     w_re,
	input  logic signed [r2fft_pkg::TW_W-1:0]     w_im,
	output logic signed [BIN_W-1:0]               sum_re,
	output logic signed [BIN_W-1:0]               sum_im,
	output logic signed [BIN_W-1:0]               dif_re,
	output logic signed [BIN_W-1:0]               dif_im
);

	localparam int PW = BIN_W + r2fft_pkg::TW_W;
	localparam int TW = PW - 14;

	logic signed [PW-1:0] m1_s1, m2_s1, m3_s2, m4_s2;
	logic signed [PW:0]   tr_acc, ti_acc;
	logic signed [TW-1:0] tr_s2;
	logic signed [TW-1:0] ti;
	logic signed [BIN_W-1:0] sum_re_s3, sum_im_s3, dif_re_s3, dif_im_s3;

	function automatic logic signed [BIN_W-1:0] sat(input logic signed [TW:0] v);
		logic signed [BIN_W-1:0] r;
		if (v[TW:BIN_W-1] == '0 || v[TW:BIN_W-1] == '1)
			r = v[BIN_W-1:0];
		else if (v[TW])
			r = {1'b1, {(BIN_W-1){1'b0}}};
		else
			r = {1'b0, {(BIN_W-1){1'b1}}};
		return r;
	endfunction

	// half-up rounding then floor shift by 15
	assign tr_acc = {m1_s1[PW-1], m1_s1} - {m2_s1[PW-1], m2_s1} + (PW+1)'(16384);
	assign ti_acc = {m3_s2[PW-1], m3_s2} + {m4_s2[PW-1], m4_s2} + (PW+1)'(16384);
	assign ti = ti_acc[PW:15];

	always_ff @(posedge clk) begin
		m1_s1 <= b_re * w_re;
		m2_s1 <= b_im * w_im;
		m3_s2 <= b_re * w_im;
		m4_s2 <= b_im * w_re;
		tr_s2 <= tr_acc[PW:15];
		sum_re_s3 <= sat({{3{a_re[BIN_W-1]}}, a_re} + {tr_s2[TW-1], tr_s2});
		dif_re_s3 <= sat({{3{a_re[BIN_W-1]}}, a_re} - {tr_s2[TW-1], tr_s2});
		sum_im_s3 <= sat({{3{a_im[BIN_W-1]}}, a_im} + {ti[TW-1], ti});
		dif_im_s3 <= sat({{3{a_im[BIN_W-1]}}, a_im} - {ti[TW-1], ti});
	end

	assign sum_re = sum_re_s3;
	assign sum_im = sum_im_s3;
	assign dif_re = dif_re_s3;
	assign dif_im = dif_im_s3;

endmodule

@@ rtl/radix2_fft_engine_core.sv @@
// Radix-2 in-place FFT core: point memory, sequencer, twiddle table and host stream ports.
//
// Usage: requests arrive on the s_ stream. Operation write stores a sample at an
// index; read fetches the stored bin into the memory read stage, then the output
// register presents it on the m_ stream with its index, one read per cycle sustained
// while m_tready stays high. Operation run transforms the first 2^log2_points entries
// in place and holds s_tready low until done: a bit-reversal sweep swapping each
// index with its reverse, then one butterfly at a time (ST_BF_RD, ST_BF_M1 to
// ST_BF_M3, ST_BF_WA, ST_BF_WB) through the single-write-port point memory, then a
// scaling sweep for the inverse. Configuration writes on cfg_we are registered at
// once; the user must keep them between runs, as the core does not enforce this.
// Reset clears the sequencer, the output valid flag and the configuration
// (log2_points 10, forward); memory contents are undefined until written.
// A stalled m_ side holds the result; one further read may be accepted and waits
// in the memory read stage, after which s_tready drops until the result moves.
module radix2_fft_engine_core #(
	parameter int MAX_LOG2    = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// operation, index, sample_re, sample_im
	input  logic [((2+MAX_LOG2+2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// bin_re, bin_im, bin_index
	output logic [((2*(SAMPLE_BITS+MAX_LOG2+1)+MAX_LOG2+7)/8)*8-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [r2fft_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int B     = SAMPLE_BITS + MAX_LOG2 + 1;
	localparam int PTS   = 1 << MAX_LOG2;
	localparam int HPTS  = PTS / 2;
	localparam int AW    = MAX_LOG2;
	localparam int TWA   = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;
	localparam int LGW   = $clog2(MAX_LOG2 + 1);
	localparam int OUT_W = 2 * B + MAX_LOG2;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
	localparam int TWW   = r2fft_pkg::TW_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WAIT  = 4'd1;
	localparam logic [3:0] ST_BR_RD = 4'd2;
	localparam logic [3:0] ST_BR_WA = 4'd3;
	localparam logic [3:0] ST_BR_WB = 4'd4;
	localparam logic [3:0] ST_BF_RD = 4'd5;
	localparam logic [3:0] ST_BF_M1 = 4'd6;
	localparam logic [3:0] ST_BF_M2 = 4'd7;
	localparam logic [3:0] ST_BF_M3 = 4'd8;
	localparam logic [3:0] ST_BF_WA = 4'd9;
	localparam logic [3:0] ST_BF_WB = 4'd10;
	localparam logic [3:0] ST_SC_RD = 4'd11;
	localparam logic [3:0] ST_SC_WR = 4'd12;

	logic [3:0] state_q;
	logic [r2fft_pkg::LOG2_REG_W-1:0] log2_points_q;
	logic inverse_mode_q;
	logic [AW-1:0] cnt_q;
	logic [LGW-1:0] stage_q;
	logic [AW-1:0] addr_a_q, addr_b_q;
	logic [2*TWW-1:0] tw_q;
	logic [2*TWW-1:0] tw_rom [HPTS];

	logic [2*B-1:0] mem [PTS];
	logic [2*B-1:0] rd_a_q, rd_b_q;
	logic rd_en_a, rd_en_b;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic we;
	logic [AW-1:0] waddr;
	logic [2*B-1:0] wdata;

	logic pend_s1;
	logic [AW-1:0] idx_s1;
	logic out_valid_q;
	logic [OUT_W-1:0] out_q;
	logic out_load, s1_free;

	logic [r2fft_pkg::OP_W-1:0] in_op;
	logic [AW-1:0] in_index;
	logic signed [SAMPLE_BITS-1:0] in_re, in_im;
	logic accept;

	logic [LGW-1:0] lg;
	logic [AW-1:0] n_last, bf_last, rev, kk, aa, bb, half, sm_mask;
	logic [LGW-1:0] sm1;
	logic [TWA-1:0] tw_idx;
	logic [AW-1:0] tw_full;

	logic signed [TWW-1:0] w_re, w_im, w_sin;
	logic signed [B-1:0] sum_re, sum_im, dif_re, dif_im;
	logic signed [B:0] sc_re, sc_im, rnd;

	genvar g;
	generate
		for (g = 0; g < HPTS; g++) begin : g_tw
			localparam logic [2*TWW-1:0] TWV = r2fft_pkg::tw_entry(g, MAX_LOG2);
			assign tw_rom[g] = TWV;
		end
	endgenerate

	function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int i = 0; i < AW; i++)
			r[i] = v[AW-1-i];
		return r;
	endfunction

	assign in_op    = s_tdata[1:0];
	assign in_index = s_tdata[2 +: AW];
	assign in_re    = s_tdata[2+AW +: SAMPLE_BITS];
	assign in_im    = s_tdata[2+AW+SAMPLE_BITS +: SAMPLE_BITS];
	assign accept   = s_tvalid && s_tready;

	assign out_load = pend_s1 && (!out_valid_q || m_tready);
	assign s1_free  = !pend_s1 || out_load;
	assign s_tready = (state_q == ST_IDLE) && s1_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'(out_q);

	// address generation
	always_comb begin
		lg = (log2_points_q > MAX_LOG2) ? LGW'(MAX_LOG2) : LGW'(log2_points_q);
		n_last  = AW'(({{AW{1'b0}}, 1'b1} << lg) - 1'b1);
		bf_last = n_last >> 1;
		rev     = bitrev(cnt_q) >> (LGW'(MAX_LOG2) - lg);
		sm1     = stage_q - 1'b1;
		half    = {{(AW-1){1'b0}}, 1'b1} << sm1;
		sm_mask = half - 1'b1;
		kk      = cnt_q & sm_mask;
		aa      = ((cnt_q >> sm1) << stage_q) | kk;
		bb      = aa | half;
		tw_full = kk << (LGW'(MAX_LOG2) - stage_q);
		tw_idx  = TWA'(tw_full);
	end

	// memory port selection
	always_comb begin
		rd_en_a = 1'b0;
		rd_en_b = 1'b0;
		rd_addr_a = in_index;
		rd_addr_b = rev;
		we = 1'b0;
		waddr = in_index;
		wdata = {B'(in_im), B'(in_re)};
		unique case (state_q)
			ST_IDLE: begin
				rd_en_a = accept && (in_op == r2fft_pkg::OP_READ);
				we      = accept && (in_op == r2fft_pkg::OP_WRITE);
			end
			ST_BR_RD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				rd_addr_a = cnt_q;
			end
			ST_BR_WA: begin
				we = 1'b1;
				waddr = cnt_q;
				wdata = rd_b_q;
			end
			ST_BR_WB: begin
				we = 1'b1;
				waddr = addr_b_q;
				wdata = rd_a_q;
			end
			ST_BF_RD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				rd_addr_a = aa;
				rd_addr_b = bb;
			end
			ST_BF_WA: begin
				we = 1'b1;
				waddr = addr_a_q;
				wdata = {sum_im, sum_re};
			end
			ST_BF_WB: begin
				we = 1'b1;
				waddr = addr_b_q;
				wdata = {dif_im, dif_re};
			end
			ST_SC_RD: begin
				rd_en_a = 1'b1;
				rd_addr_a = cnt_q;
			end
			ST_SC_WR: begin
				we = 1'b1;
				waddr = cnt_q;
				wdata = {sc_im[B-1:0], sc_re[B-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en_a)
			rd_a_q <= mem[rd_addr_a];
		if (rd_en_b)
			rd_b_q <= mem[rd_addr_b];
	end

	// inverse scaling: rounded floor shift by log2 N
	always_comb begin
		rnd   = ({{B{1'b0}}, 1'b1} << lg) >> 1;
		sc_re = ($signed({rd_a_q[B-1], rd_a_q[B-1:0]}) + rnd) >>> lg;
		sc_im = ($signed({rd_a_q[2*B-1], rd_a_q[2*B-1:B]}) + rnd) >>> lg;
	end

	assign w_re  = tw_q[TWW-1:0];
	assign w_sin = tw_q[2*TWW-1:TWW];
	assign w_im  = inverse_mode_q ? w_sin : -w_sin;

	r2fft_bfly #(
		.BIN_W(B)
	) u_bfly (
		.clk   (clk),
		.a_re  (rd_a_q[B-1:0]),
		.a_im  (rd_a_q[2*B-1:B]),
		.b_re  (rd_b_q[B-1:0]),
		.b_im  (rd_b_q[2*B-1:B]),
		.w_re  (w_re),
		.w_im  (w_im),
		.sum_re(sum_re),
		.sum_im(sum_im),
		.dif_re(dif_re),
		.dif_im(dif_im)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_BR_RD)
			addr_b_q <= rev;
		if (state_q == ST_BF_RD) begin
			addr_a_q <= aa;
			addr_b_q <= bb;
			tw_q <= tw_rom[tw_idx];
		end
		if (accept)
			idx_s1 <= in_index;
		if (out_load)
			out_q <= {idx_s1, rd_a_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_points_q  <= r2fft_pkg::LOG2_REG_W'(10);
			inverse_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				r2fft_pkg::REG_LOG2_POINTS:  log2_points_q  <= cfg_data;
				r2fft_pkg::REG_INVERSE_MODE: inverse_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && in_op == r2fft_pkg::OP_READ)
				pend_s1 <= 1'b1;
			else if (out_load)
				pend_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			stage_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_op == r2fft_pkg::OP_RUN)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// the read stage is shared, let a waiting read leave first
					if (!pend_s1) begin
						cnt_q <= '0;
						state_q <= (lg == '0) ? ST_IDLE : ST_BR_RD;
					end
				end
				ST_BR_RD, ST_BR_WB: begin
					if (state_q == ST_BR_RD && rev > cnt_q) begin
						state_q <= ST_BR_WA;
					end else if (cnt_q == n_last) begin
						cnt_q <= '0;
						stage_q <= LGW'(1);
						state_q <= ST_BF_RD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_BR_RD;
					end
				end
				ST_BR_WA: state_q <= ST_BR_WB;
				ST_BF_RD: state_q <= ST_BF_M1;
				ST_BF_M1: state_q <= ST_BF_M2;
				ST_BF_M2: state_q <= ST_BF_M3;
				ST_BF_M3: state_q <= ST_BF_WA;
				ST_BF_WA: state_q <= ST_BF_WB;
				ST_BF_WB: begin
					if (cnt_q == bf_last) begin
						cnt_q <= '0;
						if (stage_q == lg) begin
							state_q <= inverse_mode_q ? ST_SC_RD : ST_IDLE;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= ST_BF_RD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_BF_RD;
					end
				end
				ST_SC_RD: state_q <= ST_SC_WR;
				ST_SC_WR: begin
					if (cnt_q == n_last) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_SC_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/r2fft_checker.sv @@
// Port-level checks for the FFT core, bound to the top level.
module r2fft_checker #(
	parameter int IN_TW  = 48,
	parameter int OUT_TW = 64
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [IN_TW-1:0]  s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == r2fft_pkg::OP_RUN |=> !s_tready)
		else $error("request taken right after a run");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == r2fft_pkg::OP_READ && !m_tvalid
		|=> ##1 m_tvalid)
		else $error("read result missing");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

endmodule

bind radix2_fft_engine_core r2fft_checker #(
	.IN_TW ($bits(s_tdata)),
	.OUT_TW($bits(m_tdata))
) u_r2fft_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the radix-2 FFT core: predicted bins versus streamed results.
`timescale 1ns / 1ps

module testbench;

	localparam int PTS        = 1024;
	localparam int MAXLG      = 10;
	localparam int BINW       = 27;
	localparam int CYCLE_CAP  = 3000000;
	localparam int OPW        = r2fft_pkg::OP_W;
	localparam int CIW        = r2fft_pkg::CFG_IDX_W;
	localparam int CDW        = r2fft_pkg::CFG_DATA_W;
	localparam logic [OPW-1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned PI_FIX = 64'd3373259426;

	typedef struct {
		logic [BINW-1:0] re;
		logic [BINW-1:0] im;
		logic [9:0]      idx;
	} bin_t;

	// Scoreboard: in-place FFT predictor plus queue of expected bins
	class fft_scoreboard;
		longint tw_c[PTS/2];
		longint tw_s[PTS/2];
		longint pt_re[PTS];
		longint pt_im[PTS];
		int unsigned lg_reg;
		bit inv_reg;
		bin_t expected_bins[$];
		int errors;
		int checked;

		function longint q15(longint v);
			longint q;
			if (v < 0)
				v = 0;
			q = (v + 16384) >>> 15;
			return (q > 32767) ? 32767 : q;
		endfunction

		function void first_quadrant(longint unsigned r, output longint c, output longint s);
			longint unsigned x, x2, tc, ts;
			longint sc, ss;
			x = (2 * r * PI_FIX + PTS / 2) / PTS;
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			sc = tc;
			ss = ts;
			for (longint unsigned n = 1; n <= 12; n++) begin
				tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
				ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n[0]) begin
					sc -= tc;
					ss -= ts;
				end else begin
					sc += tc;
					ss += ts;
				end
			end
			c = q15(sc);
			s = q15(ss);
		endfunction

		function new();
			longint c, s;
			for (int m = 0; m < PTS / 2; m++) begin
				if (m <= PTS / 4) begin
					first_quadrant(m, c, s);
					tw_c[m] = c;
					tw_s[m] = s;
				end else begin
					first_quadrant(m - PTS / 4, c, s);
					tw_c[m] = -s;
					tw_s[m] = c;
				end
			end
			lg_reg = 10;
			inv_reg = 0;
			errors = 0;
			checked = 0;
		endfunction

		function longint clip(longint v);
			longint lim;
			lim = longint'(1) <<< (BINW - 1);
			if (v > lim - 1)
				return lim - 1;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		function void set_reg(logic [CIW-1:0] ri, logic [CDW-1:0] v);
			if (ri == r2fft_pkg::REG_LOG2_POINTS)
				lg_reg = v;
			else
				inv_reg = v[0];
		endfunction

		function void transform();
			int unsigned lg, n, j, half, stp, m, a, b;
			longint t, wr, wi, br, bi, ar, ai, tr, ti, rnd;
			lg = (lg_reg > MAXLG) ? MAXLG : lg_reg;
			n = 1 << lg;
			for (int unsigned i = 0; i < n; i++) begin
				j = 0;
				for (int unsigned k = 0; k < lg; k++)
					j |= ((i >> k) & 1) << (lg - 1 - k);
				if (j > i) begin
					t = pt_re[i]; pt_re[i] = pt_re[j]; pt_re[j] = t;
					t = pt_im[i]; pt_im[i] = pt_im[j]; pt_im[j] = t;
				end
			end
			for (int unsigned len = 2; len <= n; len <<= 1) begin
				half = len / 2;
				stp = PTS / len;
				for (int unsigned base = 0; base < n; base += len) begin
					for (int unsigned k = 0; k < half; k++) begin
						m = (k * stp) & (PTS / 2 - 1);
						a = base + k;
						b = a + half;
						wr = tw_c[m];
						wi = inv_reg ? tw_s[m] : -tw_s[m];
						br = pt_re[b]; bi = pt_im[b];
						ar = pt_re[a]; ai = pt_im[a];
						tr = (br * wr - bi * wi + 16384) >>> 15;
						ti = (br * wi + bi * wr + 16384) >>> 15;
						pt_re[a] = clip(ar + tr);
						pt_im[a] = clip(ai + ti);
						pt_re[b] = clip(ar - tr);
						pt_im[b] = clip(ai - ti);
					end
				end
			end
			if (inv_reg && lg > 0) begin
				rnd = longint'(1) <<< (lg - 1);
				for (int unsigned i = 0; i < n; i++) begin
					pt_re[i] = (pt_re[i] + rnd) >>> lg;
					pt_im[i] = (pt_im[i] + rnd) >>> lg;
				end
			end
		endfunction

		function void note_request(logic [OPW-1:0] op, logic [9:0] idx,
				logic signed [15:0] re, logic signed [15:0] im);
			bin_t e;
			case (op)
				r2fft_pkg::OP_WRITE: begin
					pt_re[idx] = re;
					pt_im[idx] = im;
				end
				r2fft_pkg::OP_RUN: transform();
				r2fft_pkg::OP_READ: begin
					e.re = pt_re[idx][BINW-1:0];
					e.im = pt_im[idx][BINW-1:0];
					e.idx = idx;
					expected_bins.push_back(e);
				end
				default: ;
			endcase
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_bin(logic [63:0] d);
			bin_t e;
			checked++;
			if (expected_bins.size() == 0) begin
				report("unexpected bin, index", d[63:54], 0);
			end else begin
				e = expected_bins.pop_front();
				if (d[26:0] !== e.re)
					report("bin_re", d[26:0], e.re);
				if (d[53:27] !== e.im)
					report("bin_im", d[53:27], e.im);
				if (d[63:54] !== e.idx)
					report("bin_index", d[63:54], e.idx);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic cfg_we;
	logic [CIW-1:0] cfg_index;
	logic [CDW-1:0] cfg_data;

	fft_scoreboard sb;
	bit written[PTS];
	int idle_pct;
	int stall_pct;
	int req_count;
	int phase_count;
	longint cycles = 0;

	radix2_fft_engine_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_bin(m_tdata);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	task send(logic [OPW-1:0] op, logic [9:0] idx, logic [15:0] re, logic [15:0] im);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, im, re, idx, op};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, idx, re, im);
		if (op == r2fft_pkg::OP_WRITE)
			written[idx] = 1'b1;
		req_count++;
	endtask

	// drain outstanding bins, then let the pipeline settle
	task settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_bins.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task cfg_write(logic [CIW-1:0] ri, logic [CDW-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(ri, v);
	endtask

	function logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(3) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	function logic [9:0] pick_written(int unsigned n);
		logic [9:0] k;
		k = 10'($urandom_range(n - 1));
		if (!written[k])
			k = 0;
		return k;
	endfunction

	task fft_phase(int unsigned lg, bit inv);
		int unsigned n, nread;
		settle();
		cfg_write(r2fft_pkg::REG_LOG2_POINTS, CDW'(lg));
		cfg_write(r2fft_pkg::REG_INVERSE_MODE, CDW'(inv));
		case (phase_count % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 63; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 63; end
			default: begin idle_pct = 9; stall_pct = 9; end
		endcase
		phase_count++;
		n = 1 << ((lg > MAXLG) ? MAXLG : lg);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0) begin
				case ($urandom_range(2))
					0: send(OP_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom));
					1: send(r2fft_pkg::OP_WRITE, 10'($urandom), pick_sample(), pick_sample());
					default: send(r2fft_pkg::OP_READ, pick_written(PTS), 0, 0);
				endcase
			end
			send(r2fft_pkg::OP_WRITE, 10'(i), pick_sample(), pick_sample());
		end
		send(r2fft_pkg::OP_RUN, 10'($urandom), 16'($urandom), 16'($urandom));
		if ($urandom_range(7) == 0)
			send(r2fft_pkg::OP_RUN, 10'($urandom), 16'($urandom), 16'($urandom));
		nread = (n < 24) ? n : 24;
		for (int unsigned i = 0; i < nread; i++)
			send(r2fft_pkg::OP_READ, (n <= 24) ? 10'(i) : pick_written(n), 0, 0);
	endtask

	initial begin
		int unsigned lg;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		req_count = 0;
		phase_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// length one: data passes unchanged; unused op; index beyond N
		cfg_write(r2fft_pkg::REG_LOG2_POINTS, 4'd0);
		cfg_write(r2fft_pkg::REG_INVERSE_MODE, 4'd0);
		send(r2fft_pkg::OP_WRITE, 0, 16'h7fff, 16'h8000);
		send(r2fft_pkg::OP_RUN, 0, 0, 0);
		send(r2fft_pkg::OP_READ, 0, 0, 0);
		send(OP_UNUSED, 10'h3ff, 16'hffff, 16'hffff);
		send(r2fft_pkg::OP_WRITE, 10'h3ff, 16'h8000, 16'h7fff);
		send(r2fft_pkg::OP_READ, 10'h3ff, 0, 0);
		settle();
		cfg_write(r2fft_pkg::REG_LOG2_POINTS, 4'd1);
		cfg_write(r2fft_pkg::REG_INVERSE_MODE, 4'd1);
		send(r2fft_pkg::OP_WRITE, 0, 16'h8000, 16'h8000);
		send(r2fft_pkg::OP_WRITE, 1, 16'h7fff, 16'h7fff);
		send(r2fft_pkg::OP_RUN, 0, 0, 0);
		send(r2fft_pkg::OP_READ, 0, 0, 0);
		send(r2fft_pkg::OP_READ, 1, 0, 0);
		settle();
		cfg_write(r2fft_pkg::REG_LOG2_POINTS, 4'd2);
		cfg_write(r2fft_pkg::REG_INVERSE_MODE, 4'd0);
		for (int i = 0; i < 4; i++)
			send(r2fft_pkg::OP_WRITE, 10'(i), (i == 2) ? 16'h8000 : 16'h7fff, 16'(i));
		send(r2fft_pkg::OP_RUN, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			send(r2fft_pkg::OP_READ, 10'(i), 0, 0);

		// two longer transforms, then short random ones
		fft_phase(8, 0);
		fft_phase(7, 1);
		while (req_count < 650) begin
			case ($urandom_range(19))
				0: lg = $urandom_range(6, 5);
				1, 2, 3, 4: lg = $urandom_range(4, 3);
				default: lg = $urandom_range(2);
			endcase
			fft_phase(lg, $urandom_range(1));
		end
		settle();

		$display("%0d requests over %0d transform phases, lengths 1 to 256, both directions",
			req_count, phase_count);
		$display("%0d bins checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.expected_bins.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/r2fft_pkg.sv
rtl/r2fft_bfly.sv
rtl/radix2_fft_engine_core.sv
rtl/r2fft_checker.sv
tb/testbench.sv
